// ===== rtl/pmpt_pkg.sv =====
// Shared types and constants for the position map predecessor table.
// Holds the command, status and state encodings and the beat structs.
// No dependencies.
package pmpt_pkg;

    // Field widths fixed by the beat format.
    localparam int POS_W   = 24;
    localparam int LINE_W  = 24;
    localparam int COL_W   = 24;
    localparam int OFF_W   = 25;
    localparam int SUM_W   = 25;
    localparam int COUNT_W = 9;

    // Offset value stored for entries that carry no original offset.
    localparam logic [OFF_W-1:0] OFFSET_NONE = {OFF_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_RANGE  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_APPEND2,
        CS_SEARCH,
        CS_FINAL,
        CS_RESP
    } ctrl_state_e;

    // One table entry as it is stored in the memory.
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [OFF_W-1:0]  offset;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One command beat.
    typedef struct packed {
        logic [1:0]               command;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         range_end;
        logic [LINE_W-1:0]        source_line;
        logic [COL_W-1:0]         source_column;
        logic signed [OFF_W-1:0]  source_offset;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [1:0]         status;
        logic [LINE_W-1:0]  found_line;
        logic [SUM_W-1:0]   found_column;
        logic               found_offset_valid;
        logic [SUM_W-1:0]   found_offset;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

// ===== rtl/pmpt_cmd_if.sv =====
// Command channel of the position map predecessor table.
// Carries valid, ready and the command beat fields; uses pmpt_pkg widths.
interface pmpt_cmd_if
    import pmpt_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        range_end;
    logic [LINE_W-1:0]       source_line;
    logic [COL_W-1:0]        source_column;
    logic signed [OFF_W-1:0] source_offset;

    modport source (
        output valid, command, position, range_end, source_line, source_column,
               source_offset,
        input  ready
    );

    modport sink (
        input  valid, command, position, range_end, source_line, source_column,
               source_offset,
        output ready
    );
endinterface

// ===== rtl/pmpt_res_if.sv =====
// Result channel of the position map predecessor table.
// Carries valid, ready and the result beat fields; uses pmpt_pkg widths.
interface pmpt_res_if
    import pmpt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [LINE_W-1:0]  found_line;
    logic [SUM_W-1:0]   found_column;
    logic               found_offset_valid;
    logic [SUM_W-1:0]   found_offset;
    logic [COUNT_W-1:0] entry_count;

    modport source (
        output valid, status, found_line, found_column, found_offset_valid,
               found_offset, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, found_line, found_column, found_offset_valid,
               found_offset, entry_count,
        output ready
    );
endinterface

// ===== rtl/position_map_predecessor_table.sv =====
// Position map predecessor table: appends, clears and binary-searches one table RAM.
// One command at a time. The accepted beat is registered and then executed; add,
// clear and empty-table lookup go on to the result, add range with a second entry
// writes it; lookup makes at most floor(log2(count)) + 1 reads, then a final step.
// The next beat is accepted the cycle after the result enters the output register.
// Reset empties the table count; table contents are left as they are.
module position_map_predecessor_table
    import pmpt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    pmpt_cmd_if.sink    cmd,
    pmpt_res_if.source  res
);

    localparam int AW = $clog2(TABLE_DEPTH);

    cmd_t    cmd_beat;
    logic    wr_en;
    logic [AW-1:0] wr_addr;
    entry_t  wr_data;
    logic    rd_en;
    logic [AW-1:0] rd_addr;
    entry_t  rd_data;
    logic    done;
    logic    take;
    result_t result;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    // Gather the command beat.
    always_comb
    begin
        cmd_beat.command       = cmd.command;
        cmd_beat.position      = cmd.position;
        cmd_beat.range_end     = cmd.range_end;
        cmd_beat.source_line   = cmd.source_line;
        cmd_beat.source_column = cmd.source_column;
        cmd_beat.source_offset = cmd.source_offset;
    end

    pmpt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_in    (cmd_beat),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .done      (done),
        .take      (take),
        .result    (result)
    );

    pmpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: a finished result moves in when the slot is free.
    assign take = done && (!out_valid_reg || res.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= result;
        end
    end

    // Drive the result beat.
    assign res.valid              = out_valid_reg;
    assign res.status             = out_data_reg.status;
    assign res.found_line         = out_data_reg.found_line;
    assign res.found_column       = out_data_reg.found_column;
    assign res.found_offset_valid = out_data_reg.found_offset_valid;
    assign res.found_offset       = out_data_reg.found_offset;
    assign res.entry_count        = out_data_reg.entry_count;

endmodule

// ===== rtl/pmpt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module pmpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; read data is registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pmpt_ctrl.sv =====
// Command sequencer of the position map predecessor table: appends, clear,
// and the binary search that issues one table read per cycle.
// Depends on pmpt_pkg; drives the ports of one pmpt_ram.
module pmpt_ctrl
    import pmpt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  cmd_t                           cmd_in,
    output logic                           wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    output entry_t                         wr_data,
    output logic                           rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  entry_t                         rd_data,
    output logic                           done,
    input  logic                           take,
    output result_t                        result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    ctrl_state_e state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;

    cmd_t          cmd_reg, cmd_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    entry_t        hit_reg, hit_next;
    logic          hit_valid_reg, hit_valid_next;
    result_t       res_reg, res_next;

    logic          full;
    logic          range_second;
    logic          le;
    logic [CW-1:0] step_lo;
    logic [CW-1:0] step_hi;
    logic          step_more;
    logic [CW-1:0] step_mid;
    logic [CW-1:0] start_mid;
    logic [POS_W-1:0] pos_delta;

    assign full         = (count_reg == CW'(TABLE_DEPTH));
    assign range_second = (cmd_reg.range_end > cmd_reg.position);
    assign start_mid    = (count_reg - CW'(1)) >> 1;

    // One search step: narrow the window [lo, hi) by the entry just read.
    always_comb
    begin
        le        = (rd_data.position <= cmd_reg.position);
        step_lo   = le ? (mid_reg + CW'(1)) : lo_reg;
        step_hi   = le ? hi_reg : mid_reg;
        step_more = (step_lo < step_hi);
        step_mid  = step_lo + ((step_hi - step_lo - CW'(1)) >> 1);
    end

    assign pos_delta = cmd_reg.position - hit_reg.position;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                unique case (cmd_e'(cmd_reg.command))
                    CMD_RANGE:  state_next = range_second ? CS_APPEND2 : CS_RESP;
                    CMD_LOOKUP: state_next = (count_reg != '0) ? CS_SEARCH : CS_RESP;
                    CMD_ADD,
                    CMD_CLEAR:  state_next = CS_RESP;
                    default:    state_next = CS_RESP;
                endcase
            end
            CS_APPEND2:
            begin
                state_next = CS_RESP;
            end
            CS_SEARCH:
            begin
                if (!step_more)
                begin
                    state_next = CS_FINAL;
                end
            end
            CS_FINAL:
            begin
                state_next = CS_RESP;
            end
            CS_RESP:
            begin
                if (take)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        hit_valid_next = hit_valid_reg;
        res_next       = res_reg;
        cmd_ready      = 1'b0;
        done           = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = '{position: cmd_reg.position, line: cmd_reg.source_line,
                           column: cmd_reg.source_column, offset: OFFSET_NONE};
        rd_en          = 1'b0;
        rd_addr        = mid_reg[AW-1:0];

        unique case (state_reg)
            CS_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd_in;
                end
            end
            CS_EXEC:
            begin
                res_next        = '0;
                res_next.status = ST_OK;
                unique case (cmd_e'(cmd_reg.command))
                    CMD_ADD,
                    CMD_RANGE:
                    begin
                        if (cmd_e'(cmd_reg.command) == CMD_ADD)
                        begin
                            wr_data.offset = cmd_reg.source_offset;
                        end
                        if (full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        lo_next        = '0;
                        hi_next        = count_reg;
                        mid_next       = start_mid;
                        hit_valid_next = 1'b0;
                        rd_addr        = start_mid[AW-1:0];
                        if (count_reg != '0)
                        begin
                            rd_en = 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_MISS;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
            CS_APPEND2:
            begin
                wr_data.position = cmd_reg.range_end;
                if (full)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            CS_SEARCH:
            begin
                lo_next  = step_lo;
                hi_next  = step_hi;
                mid_next = step_mid;
                rd_addr  = step_mid[AW-1:0];
                rd_en    = step_more;
                if (le)
                begin
                    hit_next       = rd_data;
                    hit_valid_next = 1'b1;
                end
            end
            CS_FINAL:
            begin
                if (!hit_valid_reg)
                begin
                    res_next.status = ST_MISS;
                end
                else
                begin
                    res_next.found_line   = hit_reg.line;
                    res_next.found_column = {1'b0, hit_reg.column} + {1'b0, pos_delta};
                    if (!hit_reg.offset[OFF_W-1])
                    begin
                        res_next.found_offset_valid = 1'b1;
                        res_next.found_offset       = hit_reg.offset + {1'b0, pos_delta};
                    end
                end
            end
            CS_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // The count reported is the count after the command.
    always_comb
    begin
        result             = res_reg;
        result.entry_count = COUNT_W'(count_reg);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        hit_reg       <= hit_next;
        hit_valid_reg <= hit_valid_next;
        res_reg       <= res_next;
    end

endmodule
